### rtl/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared constants and types for the longest common substring block.
// ----------------------------------------------------------------------------
package lcs_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam int SYM_W       = 8;
    localparam int LEN_W       = 7;
    localparam int IDX_W       = 6;

    localparam logic KIND_SECOND = 1'b0;
    localparam logic KIND_FIRST  = 1'b1;

    typedef enum logic [0:0] {
        ST_LOAD,
        ST_EMIT
    } state_t;

endpackage

### rtl/lcs_cell.sv
// ----------------------------------------------------------------------------
// lcs_cell
// One column of the match-length row: holds a second-string symbol and the
// match length ending at that column for the previous row.
// ----------------------------------------------------------------------------
module lcs_cell #(
    parameter int LW = lcs_pkg::LEN_W
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,      // write stored symbol
    input  logic [lcs_pkg::SYM_W-1:0] load_sym,
    input  logic                      active,    // column holds a symbol
    input  logic                      step,      // new row
    input  logic                      clear,
    input  logic [lcs_pkg::SYM_W-1:0] row_sym,
    input  logic [LW-1:0]             left_len,  // neighbor's prior-row length
    output logic [LW-1:0]             len
);

    logic [lcs_pkg::SYM_W-1:0] sym_reg;
    logic [LW-1:0]             len_reg;
    logic [LW-1:0]             len_next;

    always_comb
    begin
        len_next = len_reg;
        if (clear)
        begin
            len_next = '0;
        end
        else if (step)
        begin
            len_next = (active && row_sym == sym_reg) ? left_len + 1'b1 : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sym_reg <= load_sym;
        end
    end

    assign len = len_reg;

endmodule

### rtl/longest_common_substring.sv
// ----------------------------------------------------------------------------
// longest_common_substring
// Longest common substring of two byte strings on a row of match cells.
// ----------------------------------------------------------------------------
// channel   dir  signals                                             handshake
// command   in   kind, symbol, end_of_string                         start/busy
// result    out  out_symbol, match_length, start_index, last_result,  strobe
//                overflow
//
// a string item is taken whenever busy is low; all columns of a row update
// together in the cell row, then a registered max tree over the row folds
// into the best length via rowmax_reg. a first-string item with end_of_string
// keeps busy high while that drains and while the result symbols go out in
// order (read from the first-string memory), at least one. each result is on
// the ports in the cycle after its emit cycle. reset clears all control state.
// ----------------------------------------------------------------------------
module longest_common_substring #(
    parameter int MAX_LEN = lcs_pkg::MAX_LEN_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      kind,
    input  logic [lcs_pkg::SYM_W-1:0] symbol,
    input  logic                      end_of_string,
    output logic                      strobe,
    output logic [lcs_pkg::SYM_W-1:0] out_symbol,
    output logic [lcs_pkg::LEN_W-1:0] match_length,
    output logic [lcs_pkg::IDX_W-1:0] start_index,
    output logic                      last_result,
    output logic                      overflow
);

    localparam int CW = $clog2(MAX_LEN + 1);   // counts and lengths
    localparam int AW = $clog2(MAX_LEN);       // memory address
    localparam int NP = 1 << AW;               // leaves of the max tree

    lcs_pkg::state_t state_reg, state_next;

    logic [CW-1:0] scount_reg, scount_next;
    logic [CW-1:0] fcount_reg, fcount_next;
    logic [CW-1:0] best_len_reg, best_len_next;
    logic [CW-1:0] best_end_reg, best_end_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] k_reg, k_next;
    logic          pend_reg, pend_next;      // row updated, max not yet registered
    logic [CW-1:0] pend_row_reg, pend_row_next;
    logic          pend_d_reg;               // row max registered, fold in now
    logic [CW-1:0] pend_row_d_reg;
    logic [CW-1:0] rowmax_reg;

    logic [lcs_pkg::SYM_W-1:0] first_mem [MAX_LEN];

    logic accept, is_first, s_ok, f_ok, step, clear_all, drain;
    logic [CW-1:0] lens [MAX_LEN];
    logic [CW-1:0] max_tree [1:2*NP-1];
    logic [CW-1:0] rowmax_c;
    logic [CW-1:0] start_pos;
    logic [CW-1:0] rd_addr;

    assign accept   = start && !busy;
    assign is_first = kind == lcs_pkg::KIND_FIRST;
    assign s_ok     = scount_reg < CW'(MAX_LEN);
    assign f_ok     = fcount_reg < CW'(MAX_LEN);
    assign step     = accept && is_first && f_ok;
    assign drain    = pend_reg || pend_d_reg;

    genvar g;
    generate
        for (g = 0; g < MAX_LEN; g++)
        begin : g_cell
            logic [CW-1:0] left;
            if (g == 0)
            begin : g_edge
                assign left = '0;
            end
            else
            begin : g_in
                assign left = lens[g-1];
            end
            lcs_cell #(.LW(CW)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .load     (accept && !is_first && s_ok && scount_reg == CW'(g)),
                .load_sym (symbol),
                .active   (CW'(g) < scount_reg),
                .step     (step),
                .clear    (clear_all),
                .row_sym  (symbol),
                .left_len (left),
                .len      (lens[g])
            );
        end
    endgenerate

    // max over the row as a balanced tree; only the value matters since
    // the row index is the same for every column
    genvar n;
    generate
        for (n = 0; n < NP; n++)
        begin : g_leaf
            if (n < MAX_LEN)
            begin : g_used
                assign max_tree[NP+n] = lens[n];
            end
            else
            begin : g_pad
                assign max_tree[NP+n] = '0;
            end
        end
        for (n = 1; n < NP; n++)
        begin : g_node
            assign max_tree[n] = (max_tree[2*n] > max_tree[2*n+1]) ?
                                 max_tree[2*n] : max_tree[2*n+1];
        end
    endgenerate

    assign rowmax_c  = max_tree[1];
    assign start_pos = best_end_reg - best_len_reg;
    assign rd_addr   = start_pos + k_reg;

    always_comb
    begin
        state_next    = state_reg;
        scount_next   = scount_reg;
        fcount_next   = fcount_reg;
        best_len_next = best_len_reg;
        best_end_next = best_end_reg;
        ovf_next      = ovf_reg;
        k_next        = k_reg;
        pend_next     = 1'b0;
        pend_row_next = pend_row_reg;
        clear_all     = 1'b0;
        busy          = state_reg != lcs_pkg::ST_LOAD;
        if (pend_d_reg && rowmax_reg > best_len_reg)
        begin
            best_len_next = rowmax_reg;
            best_end_next = pend_row_d_reg;
        end
        unique case (state_reg)
            lcs_pkg::ST_LOAD:
            begin
                if (accept)
                begin
                    if (!is_first)
                    begin
                        if (s_ok)
                            scount_next = scount_reg + 1'b1;
                        else
                            ovf_next = 1'b1;
                    end
                    else
                    begin
                        if (f_ok)
                        begin
                            fcount_next   = fcount_reg + 1'b1;
                            pend_next     = 1'b1;
                            pend_row_next = fcount_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        if (end_of_string)
                        begin
                            state_next = lcs_pkg::ST_EMIT;
                            k_next     = '0;
                        end
                    end
                end
            end
            lcs_pkg::ST_EMIT:
            begin
                // emit waits until the last row max is folded in
                if (!drain)
                begin
                    k_next = k_reg + 1'b1;
                    if (k_next >= best_len_reg)
                    begin
                        state_next    = lcs_pkg::ST_LOAD;
                        clear_all     = 1'b1;
                        scount_next   = '0;
                        fcount_next   = '0;
                        best_len_next = '0;
                        best_end_next = '0;
                        ovf_next      = 1'b0;
                        k_next        = '0;
                    end
                end
            end
            default:
            begin
                state_next = lcs_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lcs_pkg::ST_LOAD;
            scount_reg     <= '0;
            fcount_reg     <= '0;
            best_len_reg   <= '0;
            best_end_reg   <= '0;
            ovf_reg        <= 1'b0;
            k_reg          <= '0;
            pend_reg       <= 1'b0;
            pend_row_reg   <= '0;
            pend_d_reg     <= 1'b0;
            pend_row_d_reg <= '0;
            strobe         <= 1'b0;
            last_result    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scount_reg     <= scount_next;
            fcount_reg     <= fcount_next;
            best_len_reg   <= best_len_next;
            best_end_reg   <= best_end_next;
            ovf_reg        <= ovf_next;
            k_reg          <= k_next;
            pend_reg       <= pend_next;
            pend_row_reg   <= pend_row_next;
            pend_d_reg     <= pend_reg;
            pend_row_d_reg <= pend_row_reg;
            strobe         <= state_reg == lcs_pkg::ST_EMIT && !drain;
            last_result    <= state_reg == lcs_pkg::ST_EMIT && !drain
                              && k_reg + 1'b1 >= best_len_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rowmax_reg <= rowmax_c;
        if (step)
        begin
            first_mem[fcount_reg[AW-1:0]] <= symbol;
        end
        if (state_reg == lcs_pkg::ST_EMIT && !drain)
        begin
            out_symbol   <= best_len_reg == '0 ? '0 : first_mem[rd_addr[AW-1:0]];
            match_length <= lcs_pkg::LEN_W'(best_len_reg);
            start_index  <= lcs_pkg::IDX_W'(start_pos);
            overflow     <= ovf_reg;
        end
    end

endmodule

### dv/lcs_checker.sv
// ----------------------------------------------------------------------------
// lcs_checker
// Watches the command and result channels of the longest common substring
// block, predicts the substring results of each run and compares them.
// ----------------------------------------------------------------------------
module lcs_checker #(
    parameter int MAX_LEN = lcs_pkg::MAX_LEN_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic                      kind,
    input  logic [lcs_pkg::SYM_W-1:0] symbol,
    input  logic                      end_of_string,
    input  logic                      strobe,
    input  logic [lcs_pkg::SYM_W-1:0] out_symbol,
    input  logic [lcs_pkg::LEN_W-1:0] match_length,
    input  logic [lcs_pkg::IDX_W-1:0] start_index,
    input  logic                      last_result,
    input  logic                      overflow,
    output int                        fail_count,
    output int                        pending
);

    typedef struct packed {
        logic [lcs_pkg::SYM_W-1:0] sym;
        logic [lcs_pkg::LEN_W-1:0] len;
        logic [lcs_pkg::IDX_W-1:0] idx;
        logic                      last;
        logic                      ovf;
    } substr_sym_t;

    substr_sym_t               substr_q[$];
    logic [lcs_pkg::SYM_W-1:0] str_b[MAX_LEN];
    logic [lcs_pkg::SYM_W-1:0] str_a[MAX_LEN];
    int                        len_b, len_a;
    int                        diag[MAX_LEN+1];
    int                        best_len, best_row;
    logic                      ovf_seen;

    initial fail_count = 0;
    assign pending = substr_q.size();

    task automatic report(input string what);
        fail_count++;
        $display("lcs_checker: mismatch at %0t: %s", $time, what);
    endtask

    task automatic clear_run();
        len_b = 0;
        len_a = 0;
        best_len = 0;
        best_row = 0;
        ovf_seen = 1'b0;
        foreach (diag[j]) diag[j] = 0;
    endtask

    task automatic predict_item(input logic k, input logic [lcs_pkg::SYM_W-1:0] s,
                                input logic eos);
        int          row[MAX_LEN+1];
        int          st;
        substr_sym_t r;
        if (k == lcs_pkg::KIND_SECOND)
        begin
            if (len_b < MAX_LEN)
            begin
                str_b[len_b] = s;
                len_b++;
            end
            else
                ovf_seen = 1'b1;
            return;
        end
        if (len_a < MAX_LEN)
        begin
            row[0] = 0;
            for (int j = 1; j <= MAX_LEN; j++)
            begin
                if (j <= len_b && s == str_b[j-1])
                begin
                    row[j] = diag[j-1] + 1;
                    if (row[j] > best_len)
                    begin
                        best_len = row[j];
                        best_row = len_a + 1;
                    end
                end
                else
                    row[j] = 0;
            end
            diag = row;
            str_a[len_a] = s;
            len_a++;
        end
        else
            ovf_seen = 1'b1;
        if (!eos)
            return;
        if (best_len == 0)
        begin
            r = '{sym: '0, len: '0, idx: '0, last: 1'b1, ovf: ovf_seen};
            substr_q.push_back(r);
        end
        else
        begin
            st = best_row - best_len;
            for (int i = 0; i < best_len; i++)
            begin
                r.sym  = str_a[st+i];
                r.len  = lcs_pkg::LEN_W'(best_len);
                r.idx  = lcs_pkg::IDX_W'(st);
                r.last = (i + 1 == best_len);
                r.ovf  = ovf_seen;
                substr_q.push_back(r);
            end
        end
        clear_run();
    endtask

    initial clear_run();

    always @(posedge clk)
    begin
        substr_sym_t e;
        if (rst_n)
        begin
            if (strobe)
            begin
                if (substr_q.size() == 0)
                    report("result with nothing expected");
                else
                begin
                    e = substr_q.pop_front();
                    if (out_symbol !== e.sym)
                        report($sformatf("out_symbol %0h want %0h", out_symbol, e.sym));
                    if (match_length !== e.len)
                        report($sformatf("match_length %0d want %0d", match_length, e.len));
                    if (start_index !== e.idx)
                        report($sformatf("start_index %0d want %0d", start_index, e.idx));
                    if (last_result !== e.last)
                        report($sformatf("last_result %0b want %0b", last_result, e.last));
                    if (overflow !== e.ovf)
                        report($sformatf("overflow %0b want %0b", overflow, e.ovf));
                end
            end
            if (start && !busy)
                predict_item(kind, symbol, end_of_string);
        end
    end

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives string loads and streamed runs into the longest common substring
// block, directed corner runs first and then random runs, and gives the
// verdict from the checker's count.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LIMIT = 5000;

    logic                      clk, rst_n, start, busy, kind, end_of_string;
    logic [lcs_pkg::SYM_W-1:0] symbol;
    logic                      strobe, last_result, overflow;
    logic [lcs_pkg::SYM_W-1:0] out_symbol;
    logic [lcs_pkg::LEN_W-1:0] match_length;
    logic [lcs_pkg::IDX_W-1:0] start_index;
    int                        fail_count, pending;
    int                        idle_pct;
    int                        quiet;
    logic                      pass_ok;

    longest_common_substring i_dut (.*);

    lcs_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog on cycles without any accepted item or result
    initial quiet = 0;
    always @(posedge clk)
    begin
        if ((start && !busy) || strobe)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // start stays high after the item so the next call can follow without a gap
    task automatic send_item(input logic k, input logic [lcs_pkg::SYM_W-1:0] s,
                             input logic eos);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        kind <= k;
        symbol <= s;
        end_of_string <= eos;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    // second string of nb symbols, first string of na symbols, alphabet size span
    task automatic run_strings(input int nb, input int na, input int span);
        logic [lcs_pkg::SYM_W-1:0] base;
        base = lcs_pkg::SYM_W'($urandom);
        for (int i = 0; i < nb; i++)
            send_item(lcs_pkg::KIND_SECOND,
                      base + lcs_pkg::SYM_W'($urandom_range(span - 1)),
                      1'(($urandom_range(3) == 0)));
        for (int i = 0; i < na; i++)
            send_item(lcs_pkg::KIND_FIRST,
                      base + lcs_pkg::SYM_W'($urandom_range(span - 1)), i == na - 1);
    endtask

    initial
    begin
        start = 1'b0;
        kind = 1'b0;
        symbol = '0;
        end_of_string = 1'b0;
        idle_pct = 0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty second string, single first symbol
        send_item(lcs_pkg::KIND_FIRST, 8'h00, 1'b1);
        // extremes and an exact full match
        send_item(lcs_pkg::KIND_SECOND, 8'h00, 1'b1);
        send_item(lcs_pkg::KIND_SECOND, 8'hff, 1'b0);
        send_item(lcs_pkg::KIND_FIRST, 8'hff, 1'b0);
        send_item(lcs_pkg::KIND_FIRST, 8'h00, 1'b0);
        send_item(lcs_pkg::KIND_FIRST, 8'hff, 1'b1);
        // no match
        send_item(lcs_pkg::KIND_SECOND, 8'h55, 1'b0);
        send_item(lcs_pkg::KIND_FIRST, 8'haa, 1'b1);
        // second string appended after streaming; the best match of 2 spans both second symbols
        send_item(lcs_pkg::KIND_SECOND, 8'h01, 1'b0);
        send_item(lcs_pkg::KIND_FIRST, 8'h01, 1'b0);
        send_item(lcs_pkg::KIND_SECOND, 8'h02, 1'b0);
        send_item(lcs_pkg::KIND_FIRST, 8'h02, 1'b0);
        send_item(lcs_pkg::KIND_FIRST, 8'h01, 1'b1);
        // both strings past the limit, identical content
        for (int i = 0; i < 66; i++)
            send_item(lcs_pkg::KIND_SECOND, 8'(i), 1'b0);
        for (int i = 0; i < 67; i++)
            send_item(lcs_pkg::KIND_FIRST, 8'(i), i == 66);

        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct = (phase == 1) ? 88 : (phase == 3) ? 32 : 0;
            for (int r = 0; r < 3; r++)
                run_strings($urandom_range(1, 5), $urandom_range(1, 5),
                            (r % 3 == 0) ? 256 : $urandom_range(1, 3));
        end
        idle_pct = 0;
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        pass_ok = (fail_count == 0);
        if (pass_ok)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
